// ----- hdl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file in the block imports this package.
package spq_pkg;

    // Number of entries held by the cell chain.
    localparam int CAPACITY = 16;
    // Width of the entry counter, wide enough to hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int OCC_W = 5;

    // Operation codes carried by the op field.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Input transaction payload.
    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] data_in;
        logic [PRIO_W-1:0]        priority_in;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    // One stored entry of the queue.
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        prio;
    } t_entry;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_cmd;

endpackage

// ----- hdl/spq_cell.sv -----
// One storage cell of the sorted chain: holds one entry and moves it in step
// with its neighbors on insert and removal. Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_valid,
    input  logic               i_left_ge,
    input  spq_pkg::t_entry    i_left_entry,
    input  spq_pkg::t_entry    i_right_entry,
    output logic               o_ge,
    output spq_pkg::t_entry    o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // A valid entry with priority at least the new one stays ahead of it.
    assign o_ge = i_valid && (r_entry.prio >= i_cmd.item.prio);

    // Insert: keep, take the new entry at the boundary, or take the left
    // neighbor. Removal: take the right neighbor.
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq) begin
            if (o_ge) begin
                n_entry = r_entry;
            end else if (i_left_ge) begin
                n_entry = i_cmd.item;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_cmd.deq) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule

// ----- hdl/spq_ctrl.sv -----
// Controller of the sorted priority queue: handshakes, entry count and the
// registered result. Depends on spq_pkg.
module spq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spq_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spq_pkg::t_out_item  o_out,
    input  spq_pkg::t_entry     i_head,
    output spq_pkg::t_cell_cmd  o_cmd,
    output logic [spq_pkg::CNT_W-1:0] o_count
);
    import spq_pkg::*;

    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_full;
    logic             w_empty;

    // The output register frees up in the same cycle it is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    // Cell commands and the result of the accepted transaction.
    always_comb begin
        o_cmd.enq       = w_accept && (i_in.op == OP_ENQ) && !w_full;
        o_cmd.deq       = w_accept && (i_in.op == OP_DEQ) && !w_empty;
        o_cmd.item.data = i_in.data_in;
        o_cmd.item.prio = i_in.priority_in;

        n_count = r_count;
        if (o_cmd.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (o_cmd.deq) begin
            n_count = r_count - CNT_W'(1);
        end

        n_out.data_out  = '0;
        n_out.status    = ST_DONE;
        n_out.occupancy = OCC_W'(n_count);
        if (i_in.op == OP_ENQ) begin
            if (w_full) begin
                n_out.status = ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_out.status = ST_EMPTY;
            end else begin
                n_out.data_out = i_head.data;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_count     = r_count;
endmodule

// ----- hdl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a controller and a chain of cells
// kept in descending priority order. Depends on spq_pkg, spq_ctrl, spq_cell.
//
//   Channel  Signals                          Payload
//   input    i_in_valid / o_in_ready          i_in  (op, data_in, priority_in)
//   output   o_out_valid / i_out_ready        o_out (data_out, status, occupancy)
//
// On each accepted transaction, all cells compare against the new priority
// in parallel and shift one place in the same clock edge, and the result
// lands in an output register in the cycle after acceptance.
// A new transaction is accepted while the result register is empty or being
// taken, so the queue runs at one transaction per cycle while the receiver
// keeps taking results; when it holds off, the input stalls until it takes one.
// Reset clears the entry count and the result valid; no clearing pass.
module sorted_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_item o_out
);
    import spq_pkg::*;

    t_cell_cmd        w_cmd;
    logic [CNT_W-1:0] w_count;
    t_entry           w_entry [CAPACITY];
    logic             w_ge    [CAPACITY];
    logic             w_valid [CAPACITY];

    // Handshakes, count and result register.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_head      (w_entry[0]),
        .o_cmd       (w_cmd),
        .o_count     (w_count)
    );

    // The chain of cells; cell 0 is the front of the queue.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g] = (w_count > CNT_W'(g));

        if (g == 0) begin : g_head
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_valid       (w_valid[g]),
                .i_left_ge     (1'b1),
                .i_left_entry  (w_cmd.item),
                .i_right_entry ((g + 1 < CAPACITY) ? w_entry[(g + 1) % CAPACITY]
                                                   : w_entry[g]),
                .o_ge          (w_ge[g]),
                .o_entry       (w_entry[g])
            );
        end else if (g == CAPACITY - 1) begin : g_tail
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_valid       (w_valid[g]),
                .i_left_ge     (w_ge[g - 1]),
                .i_left_entry  (w_entry[g - 1]),
                .i_right_entry (w_entry[g]),
                .o_ge          (w_ge[g]),
                .o_entry       (w_entry[g])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_valid       (w_valid[g]),
                .i_left_ge     (w_ge[g - 1]),
                .i_left_entry  (w_entry[g - 1]),
                .i_right_entry (w_entry[g + 1]),
                .o_ge          (w_ge[g]),
                .o_entry       (w_entry[g])
            );
        end
    end
endmodule

// ----- sim/sorted_priority_queue_tb.sv -----
// Self-checking testbench for the sorted priority queue: random and directed
// enqueue/dequeue traffic, checked against a behavioral copy of the queue.
// Depends on spq_pkg and the sorted_priority_queue top level.
module sorted_priority_queue_tb;

    import spq_pkg::*;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    // How often a side of the testbench inserts idle cycles.
    typedef enum int {
        IDLE_NONE,
        IDLE_SOME,
        IDLE_FULL
    } t_idle;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out;

    // Shadow copy of the stored entries, front first.
    t_entry    shadow_entries[$];
    // Results predicted but not yet taken from the output channel.
    t_out_item awaited_results[$];

    t_idle     in_idle_mode = IDLE_NONE;
    t_idle     out_idle_mode = IDLE_NONE;
    logic      out_hold = 1'b0;
    int        out_stall_left = 0;
    int        results_taken = 0;
    int        mismatch_count = 0;

    sorted_priority_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Number of idle cycles before the next transaction on one side.
    function automatic int draw_gap(input t_idle mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
            default:   return $urandom_range(0, 18);
        endcase
    endfunction

    // Applies one transaction to the shadow queue and returns its result.
    function automatic t_out_item predict_result(input t_in_item item);
        t_out_item res;
        t_entry    entry;
        int        pos;
        res.data_out = '0;
        res.status = ST_DONE;
        if (item.op == OP_ENQ) begin
            if (shadow_entries.size() >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // Ties go behind the entries already stored.
                pos = 0;
                while (pos < shadow_entries.size() &&
                       shadow_entries[pos].prio >= item.priority_in) begin
                    pos++;
                end
                entry.data = item.data_in;
                entry.prio = item.priority_in;
                shadow_entries.insert(pos, entry);
            end
        end else if (shadow_entries.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            entry = shadow_entries.pop_front();
            res.data_out = entry.data;
        end
        res.occupancy = OCC_W'(shadow_entries.size());
        return res;
    endfunction

    function automatic t_in_item make_item(input logic op, input logic [31:0] data,
                                           input logic [15:0] prio);
        t_in_item item;
        item.op = op;
        item.data_in = data;
        item.priority_in = prio;
        return item;
    endfunction

    // Priorities lean toward small sets so that ties are common.
    function automatic logic [15:0] draw_priority();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 3));
            1:       return 16'($urandom);
            2:       return ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
            default: return 16'($urandom_range(16'h7ffe, 16'h8001));
        endcase
    endfunction

    function automatic t_in_item random_item(input int enq_pct);
        logic op;
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        return make_item(op, $urandom, draw_priority());
    endfunction

    // Offers one transaction and waits until the block accepts it. Valid stays
    // high afterwards so back-to-back transactions need no extra edge.
    task automatic send_item(input t_in_item item);
        int gap;
        gap = draw_gap(in_idle_mode);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        awaited_results.push_back(predict_result(item));
    endtask

    // Drops valid and waits on the clock so the next offer starts cleanly.
    task automatic hold_input();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_out_item want,
                                 input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch (%s): expected data %h status %s occ %0d,",
                     what, want.data_out, want.status.name(), want.occupancy,
                     " got data %h status %s occ %0d",
                     got.data_out, got.status.name(), got.occupancy);
        end
    endtask

    // Compares one taken result against the oldest prediction.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (awaited_results.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
        end else begin
            want = awaited_results.pop_front();
            if (got.data_out !== want.data_out)
                note_mismatch("data_out", want, got);
            else if (got.status !== want.status)
                note_mismatch("status", want, got);
            else if (got.occupancy !== want.occupancy)
                note_mismatch("occupancy", want, got);
        end
    endtask

    // Output side: take results, then stall for a random number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && out_ready) begin
            check_result(o_out);
            results_taken++;
            if (results_taken % 64 == 0) begin
                out_idle_mode = t_idle'($urandom_range(0, 2));
            end
            out_stall_left = draw_gap(out_idle_mode);
        end else if (out_stall_left > 0) begin
            out_stall_left--;
        end
        out_ready <= !out_hold && out_stall_left == 0;
    end

    // Empty dequeue, field extremes, equal priorities, filling up and overflow.
    task automatic test_directed_cases();
        int idx;
        in_idle_mode = IDLE_SOME;
        send_item(make_item(OP_DEQ, 32'h0, 16'h0));
        send_item(make_item(OP_ENQ, 32'h7fffffff, 16'hffff));
        send_item(make_item(OP_ENQ, 32'h80000000, 16'h0000));
        send_item(make_item(OP_ENQ, 32'h00000000, 16'h0000));
        send_item(make_item(OP_ENQ, 32'hffffffff, 16'hffff));
        send_item(make_item(OP_ENQ, 32'haaaaaaaa, 16'h5555));
        send_item(make_item(OP_ENQ, 32'h55555555, 16'haaaa));
        send_item(make_item(OP_ENQ, 32'h00000001, 16'h8000));
        for (idx = 0; idx < CAPACITY - 7; idx++) begin
            send_item(make_item(OP_ENQ, 32'(idx + 100), 16'h8000));
        end
        // The queue is now full, so this one is dropped.
        send_item(make_item(OP_ENQ, 32'h12345678, 16'hffff));
        for (idx = 0; idx < 3; idx++) begin
            send_item(make_item(OP_DEQ, $urandom, 16'($urandom)));
        end
        hold_input();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_output_backpressure();
        int idx;
        in_idle_mode = IDLE_NONE;
        fork
            begin
                out_hold <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                out_hold <= 1'b0;
            end
        join_none
        for (idx = 0; idx < 60; idx++) begin
            send_item(random_item(60));
        end
        hold_input();
        wait_drained();
    endtask

    // The sender stops until every outstanding result is back, then resumes.
    task automatic test_drain_pause();
        int round;
        int idx;
        for (round = 0; round < 3; round++) begin
            in_idle_mode = t_idle'($urandom_range(0, 2));
            for (idx = 0; idx < 20; idx++) begin
                send_item(random_item(55));
            end
            hold_input();
            wait_drained();
        end
    endtask

    // Long random run; the enqueue share shifts so the queue swings between
    // empty and full many times.
    task automatic test_random_traffic(input int n_items);
        int enq_pct;
        int idx;
        enq_pct = 50;
        for (idx = 0; idx < n_items; idx++) begin
            if (idx % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0:       enq_pct = 25;
                    1:       enq_pct = 50;
                    default: enq_pct = 75;
                endcase
                in_idle_mode = t_idle'($urandom_range(0, 2));
            end
            send_item(random_item(enq_pct));
        end
        hold_input();
    endtask

    // Main sequence: reset, the tests in turn, then drain and report.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic(660);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("tb: failure");
        $finish;
    end

endmodule
